// File: hdl/sclp_pkg.sv
`default_nettype none
package sclp_pkg;

	localparam int LINE_CHARS_DEF = 20;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_CR  = 8'd13;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_SP  = 8'd32;

	localparam int PREFIX_LEN = 4;
	localparam logic [9:0] CHAN_LIMIT  = 10'd512;
	localparam logic [9:0] LEVEL_LIMIT = 10'd256;
	localparam logic [1:0] MAX_DIGITS  = 2'd3;

	typedef enum logic [1:0] {
		KIND_ECHO      = 2'd0,
		KIND_WRITE     = 2'd1,
		KIND_PARSE_ERR = 2'd2,
		KIND_LIMIT     = 2'd3
	} kind_t;

	// control from the sequencer to the line parser
	typedef struct packed {
		logic       clear;
		logic       ch_valid;
		logic [7:0] ch;
	} scan_ctl_t;

	// outcome of a parsed line
	typedef struct packed {
		kind_t      kind;
		logic [8:0] channel;
		logic [7:0] level;
	} verdict_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_text(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
			(c == CH_SP);
	endfunction

	// characters of the "set " command word
	function automatic logic [7:0] prefix_char(input logic [1:0] i);
		logic [7:0] c;
		unique case (i)
			2'd0: c = 8'h73;
			2'd1: c = 8'h65;
			2'd2: c = 8'h74;
			default: c = CH_SP;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// File: hdl/sclp_rx_if.sv
`default_nettype none
interface sclp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/sclp_res_if.sv
`default_nettype none
interface sclp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] echo_byte;
	logic [8:0] channel;
	logic [7:0] level;
	logic       last;

	modport source (output valid, output kind, output echo_byte, output channel,
		output level, output last, input ready);
	modport sink (input valid, input kind, input echo_byte, input channel,
		input level, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/sclp_ram.sv
`default_nettype none
module sclp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 20,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write one entry, read one entry registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/sclp_parse.sv
`default_nettype none
module sclp_parse
	import sclp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF,
	localparam int CW = $clog2(LINE_CHARS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scan_ctl_t     ctl,
	input  wire logic [CW-1:0] pos,
	input  wire logic [CW-1:0] len,
	output verdict_t           verdict
);

	logic       prefix_ok_q;
	logic       fail_q;
	logic       in_val_q;
	logic [1:0] nch_q;
	logic [1:0] nval_q;
	logic [9:0] chn_q;
	logic [9:0] val_q;

	logic [3:0] digit;
	logic [9:0] chn_next;
	logic [9:0] val_next;
	logic       body;

	assign digit    = ctl.ch[3:0];
	assign chn_next = {chn_q[6:0], 3'b000} + {chn_q[8:0], 1'b0} + {6'd0, digit};
	assign val_next = {val_q[6:0], 3'b000} + {val_q[8:0], 1'b0} + {6'd0, digit};
	assign body     = (pos >= CW'(PREFIX_LEN));

	// fold one stored character into the running parse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_ok_q <= 1'b1;
			fail_q      <= 1'b0;
			in_val_q    <= 1'b0;
			nch_q       <= 2'd0;
			nval_q      <= 2'd0;
			chn_q       <= 10'd0;
			val_q       <= 10'd0;
		end else if (ctl.clear) begin
			prefix_ok_q <= 1'b1;
			fail_q      <= 1'b0;
			in_val_q    <= 1'b0;
			nch_q       <= 2'd0;
			nval_q      <= 2'd0;
			chn_q       <= 10'd0;
			val_q       <= 10'd0;
		end else if (ctl.ch_valid && !body) begin
			if (ctl.ch != prefix_char(pos[1:0])) begin
				prefix_ok_q <= 1'b0;
			end
		end else if (ctl.ch_valid && !fail_q) begin
			if (is_digit(ctl.ch)) begin
				if (!in_val_q) begin
					if (nch_q < MAX_DIGITS) begin
						chn_q <= chn_next;
						nch_q <= nch_q + 2'd1;
					end else begin
						fail_q <= 1'b1;
					end
				end else begin
					if (nval_q < MAX_DIGITS) begin
						val_q  <= val_next;
						nval_q <= nval_q + 2'd1;
					end else begin
						fail_q <= 1'b1;
					end
				end
			end else if (ctl.ch == CH_SP) begin
				in_val_q <= 1'b1;
			end else begin
				fail_q <= 1'b1;
			end
		end
	end

	// classify the finished line
	always_comb begin
		verdict.kind    = KIND_PARSE_ERR;
		verdict.channel = 9'd0;
		verdict.level   = 8'd0;
		if ((len > CW'(PREFIX_LEN)) && prefix_ok_q && !fail_q &&
				(nch_q != 2'd0) && (nval_q != 2'd0)) begin
			if ((chn_q < CHAN_LIMIT) && (val_q < LEVEL_LIMIT)) begin
				verdict.kind    = KIND_WRITE;
				verdict.channel = chn_q[8:0];
				verdict.level   = val_q[7:0];
			end else begin
				verdict.kind = KIND_LIMIT;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/serial_command_line_parser_unit.sv
`default_nettype none
// An edit byte is held in a byte register on acceptance and its echo item is loaded
// from the echo state once the output register is free. An end-of-line byte gives
// CR and LF echoes, then walks the stored line through the single read port of the
// line memory, one character a cycle; its outcome item is loaded once the last read
// has landed and the output register is free. New bytes are taken only when idle.
// Reset: clears the cursor and control; the line memory is left undefined.
module serial_command_line_parser_unit
	import sclp_pkg::*;
#(
	parameter int LINE_CHARS = LINE_CHARS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sclp_rx_if.sink    rx,
	sclp_res_if.source res
);

	localparam int CW = $clog2(LINE_CHARS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ECHO,
		ST_CR,
		ST_LF,
		ST_SCAN,
		ST_RESULT
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cursor_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    byte_q;
	logic          rd_valid_s1;
	logic [CW-1:0] pos_s1;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [7:0]    out_echo_q;
	logic [8:0]    out_chan_q;
	logic [7:0]    out_level_q;
	logic          out_last_q;

	logic       accept;
	logic       is_erase;
	logic       is_eol;
	logic       is_char;
	logic       out_free;
	logic       out_load;
	logic       rd_issue;
	logic [7:0] rdata;
	scan_ctl_t  ctl;
	verdict_t   verdict;

	assign rx.ready  = (state_q == ST_IDLE);
	assign accept    = rx.valid && rx.ready;
	assign is_erase  = (rx.rx_byte == CH_BS) || (rx.rx_byte == CH_DEL);
	assign is_eol    = (rx.rx_byte == CH_CR) || (rx.rx_byte == CH_LF);
	assign is_char   = is_digit(rx.rx_byte) || is_text(rx.rx_byte);
	assign out_free  = !out_valid_q || res.ready;
	assign out_load  = out_free && ((state_q == ST_ECHO) || (state_q == ST_CR) ||
		(state_q == ST_LF) || (state_q == ST_RESULT));
	assign rd_issue  = (state_q == ST_SCAN) && (idx_q != len_q);

	assign ctl.clear    = accept && is_eol;
	assign ctl.ch_valid = rd_valid_s1;
	assign ctl.ch       = rdata;

	assign res.valid     = out_valid_q;
	assign res.kind      = out_kind_q;
	assign res.echo_byte = out_echo_q;
	assign res.channel   = out_chan_q;
	assign res.level     = out_level_q;
	assign res.last      = out_last_q;

	sclp_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CHARS)
	) u_line_ram (
		.clk  (clk),
		.we   (accept && is_char),
		.waddr(cursor_q),
		.wdata(rx.rx_byte),
		.raddr(idx_q),
		.rdata(rdata)
	);

	sclp_parse #(
		.LINE_CHARS(LINE_CHARS)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_s1),
		.len    (len_q),
		.verdict(verdict)
	);

	// sequence edits, echoes and the line walk; hold results in the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cursor_q    <= '0;
			len_q       <= '0;
			idx_q       <= '0;
			byte_q      <= 8'd0;
			rd_valid_s1 <= 1'b0;
			pos_s1      <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_ECHO;
			out_echo_q  <= 8'd0;
			out_chan_q  <= 9'd0;
			out_level_q <= 8'd0;
			out_last_q  <= 1'b0;
		end else begin
			// drop a taken item unless a new one replaces it
			if (res.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			rd_valid_s1 <= rd_issue;
			pos_s1      <= idx_q;

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						byte_q <= rx.rx_byte;
						if (is_erase) begin
							if (cursor_q != '0) begin
								cursor_q <= cursor_q - CW'(1);
							end
							state_q <= ST_ECHO;
						end else if (is_eol) begin
							len_q    <= cursor_q;
							idx_q    <= '0;
							cursor_q <= '0;
							state_q  <= ST_CR;
						end else if (is_char) begin
							if (cursor_q != CW'(LINE_CHARS - 1)) begin
								cursor_q <= cursor_q + CW'(1);
							end
							state_q <= ST_ECHO;
						end
					end
				end
				ST_ECHO: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_ECHO;
						out_echo_q  <= byte_q;
						out_chan_q  <= 9'd0;
						out_level_q <= 8'd0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				ST_CR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_ECHO;
						out_echo_q  <= CH_CR;
						out_chan_q  <= 9'd0;
						out_level_q <= 8'd0;
						out_last_q  <= 1'b0;
						state_q     <= ST_LF;
					end
				end
				ST_LF: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= KIND_ECHO;
						out_echo_q  <= CH_LF;
						out_chan_q  <= 9'd0;
						out_level_q <= 8'd0;
						out_last_q  <= 1'b0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance the read pointer; finish once the last read has landed
					if (rd_issue) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rd_valid_s1) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= verdict.kind;
						out_echo_q  <= 8'd0;
						out_chan_q  <= verdict.channel;
						out_level_q <= verdict.level;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
